/* src/lfs_pkg.sv */
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared types, constants and elaboration-time functions of the line follow
// steering block: register map, microcode word layout, microprogram and the
// sigmoid table generator.
// ----------------------------------------------------------------------------
package lfs_pkg;

	// Field widths
	localparam int unsigned POS_W   = 16;
	localparam int unsigned CMD_W   = 11;
	localparam int unsigned CFG_W   = 34;
	localparam int unsigned CIDX_W  = 3;
	localparam int unsigned TBL_W   = 22;
	localparam int unsigned PC_W    = 5;
	localparam int unsigned CNT_W   = 4;

	localparam int unsigned SIG_ENTRIES_DEF = 256;
	localparam logic [CNT_W-1:0] DIV_LAST = 4'd15;

	localparam logic [CMD_W-1:0] CMD_BASE = 11'd1000;

	// Register reset values
	localparam logic [15:0] HG_RST    = 16'd922;
	localparam logic [11:0] DG_RST    = 12'd500;
	localparam logic [9:0]  SCALE_RST = 10'd200;

	// Register map
	localparam logic [CIDX_W-1:0] REG_LINE_A    = 3'd0;
	localparam logic [CIDX_W-1:0] REG_LINE_B    = 3'd1;
	localparam logic [CIDX_W-1:0] REG_LINE_C    = 3'd2;
	localparam logic [CIDX_W-1:0] REG_TARGET_HD = 3'd3;
	localparam logic [CIDX_W-1:0] REG_HD_GAIN   = 3'd4;
	localparam logic [CIDX_W-1:0] REG_DIST_GAIN = 3'd5;
	localparam logic [CIDX_W-1:0] REG_SIG_SCALE = 3'd6;

	typedef struct packed {
		logic signed [16:0] line_a;
		logic signed [16:0] line_b;
		logic signed [33:0] line_c;
		logic [14:0]        target_heading;
		logic [15:0]        heading_gain;
		logic [11:0]        distance_gain;
		logic [9:0]         sigmoid_scale;
	} cfg_t;

	// Microcode word fields
	typedef enum logic [2:0] {
		A_LA, A_LB, A_HG, A_ROM, A_NENT
	} a_sel_t;

	typedef enum logic [2:0] {
		B_X, B_Y, B_ERR, B_P, B_WFRAC, B_FRAC
	} b_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_ADDC
	} acc_op_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_ERR, OP_HQ, OP_SIDE, OP_SUM, OP_DINIT, OP_DCHK,
		OP_DSTEP, OP_CLAMP, OP_IDX, OP_CMD, OP_EMIT
	} dp_op_t;

	typedef enum logic [2:0] {
		J_NEXT, J_GOTO, J_WAIT_IN, J_LOOP, J_SAME, J_WAIT_OUT
	} jmp_t;

	typedef struct packed {
		a_sel_t          a_sel;
		b_sel_t          b_sel;
		logic            mul_en;
		acc_op_t         acc_op;
		dp_op_t          op;
		logic            rom_hi;
		logic            ld_cnt;
		jmp_t            jmp;
		logic [PC_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic out_busy;
		logic same;
	} st_t;

	// Jump targets
	localparam logic [PC_W-1:0] PC_IDLE = 5'd0;
	localparam logic [PC_W-1:0] PC_DIV  = 5'd9;

	localparam ctrl_t CW_NOP = '{
		a_sel: A_LA, b_sel: B_X, mul_en: 1'b0, acc_op: ACC_HOLD, op: OP_NONE,
		rom_hi: 1'b0, ld_cnt: 1'b0, jmp: J_NEXT, target: PC_IDLE
	};

	// Microprogram: one control word per step
	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t w;
		w = CW_NOP;
		unique case (pc)
			5'd0: begin
				w.jmp = J_WAIT_IN;
			end
			5'd1: begin
				w.mul_en = 1'b1; w.a_sel = A_LA; w.b_sel = B_X; w.op = OP_ERR;
			end
			5'd2: begin
				w.mul_en = 1'b1; w.a_sel = A_LB; w.b_sel = B_Y; w.acc_op = ACC_LOAD;
			end
			5'd3: begin
				w.mul_en = 1'b1; w.a_sel = A_HG; w.b_sel = B_ERR; w.acc_op = ACC_ADD;
			end
			5'd4: begin
				w.acc_op = ACC_ADDC; w.op = OP_HQ;
			end
			5'd5: w.op = OP_SIDE;
			5'd6: w.op = OP_SUM;
			5'd7: w.op = OP_DINIT;
			5'd8: begin
				w.op = OP_DCHK; w.ld_cnt = 1'b1;
			end
			5'd9: begin
				w.op = OP_DSTEP; w.jmp = J_LOOP; w.target = PC_DIV;
			end
			5'd10: w.op = OP_CLAMP;
			5'd11: begin
				w.mul_en = 1'b1; w.a_sel = A_NENT; w.b_sel = B_P;
			end
			5'd12: w.op = OP_IDX;
			5'd13: w.op = OP_NONE;
			5'd14: begin
				w.mul_en = 1'b1; w.a_sel = A_ROM; w.b_sel = B_WFRAC; w.rom_hi = 1'b1;
			end
			5'd15: begin
				w.mul_en = 1'b1; w.a_sel = A_ROM; w.b_sel = B_FRAC; w.acc_op = ACC_LOAD;
			end
			5'd16: w.acc_op = ACC_ADD;
			5'd17: w.op = OP_CMD;
			5'd18: begin
				w.jmp = J_SAME; w.target = PC_IDLE;
			end
			5'd19: begin
				w.op = OP_EMIT; w.jmp = J_WAIT_OUT; w.target = PC_IDLE;
			end
			default: begin
				w.jmp = J_GOTO; w.target = PC_IDLE;
			end
		endcase
		return w;
	endfunction

	// Shift-subtract quotient, used only while building constant tables
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], num[i]};
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// 1000*sigmoid(t) in Q.12 for t in Q3.12
	function automatic logic [TBL_W-1:0] sig_q12(input logic signed [31:0] t);
		logic [63:0] u;
		logic [63:0] e;
		logic [63:0] term;
		logic [63:0] r;
		logic [63:0] q;
		logic [63:0] v;
		u = (t < 0) ? 64'(-t) : 64'(t);
		if (u > 64'd32768) u = 64'd32768;
		term = 64'd1 << 30;
		e = term;
		// exp(u/8) by truncated Taylor terms
		for (int k = 1; k <= 14; k++) begin
			term = udiv64(term * u, 64'(32768 * k));
			e = e + term;
		end
		// exp(-u) = (1/exp(u/8))^8
		r = udiv64(64'd1 << 60, e);
		for (int j = 0; j < 3; j++) begin
			r = (r * r) >> 30;
		end
		q = udiv64(64'd1 << 60, (64'd1 << 30) + r);
		v = (64'd1000 * q + (64'd1 << 17)) >> 18;
		return (t < 0) ? TBL_W'(64'd4096000 - v) : TBL_W'(v);
	endfunction

	// Table point i of n: t_i = -32768 + floor(65536*i/n)
	function automatic logic [TBL_W-1:0] sig_point(input int unsigned i, input int unsigned n);
		logic [63:0]        off;
		logic signed [31:0] ti;
		off = udiv64(64'(i) * 64'd65536, 64'(n));
		ti = $signed(off[31:0]) - 32'sd32768;
		return sig_q12(ti);
	endfunction

endpackage

/* src/lfs_in_if.sv */
// ----------------------------------------------------------------------------
// lfs_in_if
// Position sample channel: valid/ready handshake with x, y and heading.
// ----------------------------------------------------------------------------
interface lfs_in_if import lfs_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] car_heading;

	modport source (output valid, output pos_x, output pos_y, output car_heading,
		input ready);
	modport sink (input valid, input pos_x, input pos_y, input car_heading,
		output ready);
endinterface

/* src/lfs_out_if.sv */
// ----------------------------------------------------------------------------
// lfs_out_if
// Steering command channel: valid/ready handshake with the command value.
// ----------------------------------------------------------------------------
interface lfs_out_if import lfs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] steering_command;

	modport source (output valid, output steering_command, input ready);
	modport sink (input valid, input steering_command, output ready);
endinterface

/* src/lfs_sig_rom.sv */
// ----------------------------------------------------------------------------
// lfs_sig_rom
// Sigmoid table, SIGMOID_ENTRIES+1 points of 1000*sigmoid(t) in Q.12,
// built at elaboration, one registered read per cycle.
// ----------------------------------------------------------------------------
module lfs_sig_rom import lfs_pkg::*; #(
	parameter int unsigned SIGMOID_ENTRIES = SIG_ENTRIES_DEF,
	localparam int unsigned AW = $clog2(SIGMOID_ENTRIES + 1)
) (
	input  logic             clk,
	input  logic [AW-1:0]    addr,
	output logic [TBL_W-1:0] data
);

	typedef logic [TBL_W-1:0] tbl_t [0:SIGMOID_ENTRIES];

	function automatic tbl_t build_tbl();
		tbl_t t;
		for (int i = 0; i <= int'(SIGMOID_ENTRIES); i++) begin
			t[i] = sig_point(i, SIGMOID_ENTRIES);
		end
		return t;
	endfunction

	localparam tbl_t TBL = build_tbl();

	// registered table read
	always_ff @(posedge clk) begin
		data <= TBL[addr];
	end

endmodule

/* src/lfs_sequencer.sv */
// ----------------------------------------------------------------------------
// lfs_sequencer
// Step counter, microcode fetch, loop counter and conditional jumps.
// ----------------------------------------------------------------------------
module lfs_sequencer import lfs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  st_t   st,
	output ctrl_t ctrl,
	output logic  in_ready
);

	logic [PC_W-1:0]  pc_q;
	logic [PC_W-1:0]  pc_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic             cnt_nz;

	// fetch the control word of the current step
	assign ctrl     = ucode(pc_q);
	assign cnt_nz   = (cnt_q != '0);
	assign in_ready = (ctrl.jmp == J_WAIT_IN);

	// pick the next step
	always_comb begin
		pc_d = pc_q + 1'b1;
		unique case (ctrl.jmp)
			J_NEXT:     pc_d = pc_q + 1'b1;
			J_GOTO:     pc_d = ctrl.target;
			J_WAIT_IN:  pc_d = st.in_valid ? pc_q + 1'b1 : pc_q;
			J_LOOP:     pc_d = cnt_nz ? ctrl.target : pc_q + 1'b1;
			J_SAME:     pc_d = st.same ? ctrl.target : pc_q + 1'b1;
			J_WAIT_OUT: pc_d = st.out_busy ? pc_q : ctrl.target;
			default:    pc_d = PC_IDLE;
		endcase
	end

	// load or count down the loop counter
	always_comb begin
		cnt_d = cnt_q;
		if (ctrl.ld_cnt) begin
			cnt_d = DIV_LAST;
		end else if (ctrl.jmp == J_LOOP && cnt_nz) begin
			cnt_d = cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= PC_IDLE;
			cnt_q <= '0;
		end else begin
			pc_q  <= pc_d;
			cnt_q <= cnt_d;
		end
	end

`ifndef SYNTHESIS
	a_idle_cnt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == PC_IDLE) |-> (cnt_q == '0))
		else $error("loop counter left running outside the divide loop");
`endif

endmodule

/* src/lfs_datapath.sv */
// ----------------------------------------------------------------------------
// lfs_datapath
// Datapath driven by the microcode: shared multiplier, accumulator,
// bit-serial divider, table interpolation and change detection.
// ----------------------------------------------------------------------------
module lfs_datapath import lfs_pkg::*; #(
	parameter int unsigned SIGMOID_ENTRIES = SIG_ENTRIES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctrl_t                   ctrl,
	input  cfg_t                    cfg,
	input  logic                    cap,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] car_heading,
	input  logic                    emit,
	output logic                    same,
	output logic [CMD_W-1:0]        cmd
);

	localparam int unsigned AW = $clog2(SIGMOID_ENTRIES + 1);
	localparam logic [22:0]   NENT  = 23'(SIGMOID_ENTRIES);
	localparam logic [AW-1:0] IDX_TOP = AW'(SIGMOID_ENTRIES);
	localparam logic [16:0]   P_MID = 17'd32768;
	localparam logic [16:0]   P_TOP = 17'd65536;

	// captured sample
	logic signed [15:0] x_q, y_q, hd_q;

	// datapath registers
	logic signed [17:0] err_q;
	logic signed [40:0] prod_q;
	logic signed [41:0] acc_q;
	logic               side_pos_q, side_neg_q;
	logic signed [21:0] hq_q;
	logic signed [25:0] s_q;
	logic [25:0]        num_q;
	logic               neg_q;
	logic               ovf_q;
	logic [9:0]         rem_q;
	logic [15:0]        dq_q;
	logic [16:0]        p_q;
	logic [AW-1:0]      idx_q;
	logic [15:0]        frac_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [CMD_W-1:0]   last_q;

	// combinational helpers
	logic signed [22:0] a_op;
	logic signed [17:0] b_op;
	logic signed [40:0] prod_d;
	logic [9:0]         dvs;
	logic [16:0]        wfrac;
	logic [AW-1:0]      rom_addr;
	logic [TBL_W-1:0]   rom_data;
	logic [40:0]        pmag;
	logic [32:0]        hq_sum;
	logic [21:0]        hq_mag;
	logic [25:0]        dg_term;
	logic [25:0]        s_mag;
	logic [10:0]        trial;
	logic               trial_ge;
	logic [15:0]        qv;
	logic [22:0]        y_sum;

	assign dvs   = (cfg.sigmoid_scale == '0) ? 10'd1 : cfg.sigmoid_scale;
	assign wfrac = 17'h10000 - {1'b0, frac_q};

	// multiplier operand selection
	always_comb begin
		case (ctrl.a_sel)
			A_LA:    a_op = {{6{cfg.line_a[16]}}, cfg.line_a};
			A_LB:    a_op = {{6{cfg.line_b[16]}}, cfg.line_b};
			A_HG:    a_op = {7'd0, cfg.heading_gain};
			A_ROM:   a_op = {1'b0, rom_data};
			A_NENT:  a_op = NENT;
			default: a_op = '0;
		endcase
		case (ctrl.b_sel)
			B_X:     b_op = {{2{x_q[15]}}, x_q};
			B_Y:     b_op = {{2{y_q[15]}}, y_q};
			B_ERR:   b_op = err_q;
			B_P:     b_op = {1'b0, p_q};
			B_WFRAC: b_op = {1'b0, wfrac};
			B_FRAC:  b_op = {2'd0, frac_q};
			default: b_op = '0;
		endcase
	end

	assign prod_d = a_op * b_op;

	// table address: the interpolation pair, upper point held at the end
	always_comb begin
		rom_addr = idx_q;
		if (ctrl.rom_hi && idx_q != IDX_TOP) begin
			rom_addr = idx_q + 1'b1;
		end
	end

	lfs_sig_rom #(
		.SIGMOID_ENTRIES(SIGMOID_ENTRIES)
	) u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	// heading term rounded half away from zero, Q.12
	assign pmag   = prod_q[40] ? (41'd0 - prod_q) : prod_q;
	assign hq_sum = {1'b0, pmag[31:0]} + 33'd2048;
	assign hq_mag = {1'b0, hq_sum[32:12]};

	// line side term, distance gain scaled to Q.12
	assign dg_term = {2'd0, cfg.distance_gain, 12'd0};
	assign s_mag   = s_q[25] ? (26'd0 - s_q) : s_q;

	// one restoring divide step
	assign trial    = {rem_q, dq_q[15]};
	assign trial_ge = (trial >= {1'b0, dvs});
	assign qv       = ovf_q ? 16'hFFFF : dq_q;

	// command rounding
	assign y_sum = {1'b0, acc_q[37:16]} + 23'd2048;

	// sample capture
	always_ff @(posedge clk) begin
		if (cap) begin
			x_q  <= pos_x;
			y_q  <= pos_y;
			hd_q <= car_heading;
		end
	end

	// multiplier and accumulator
	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= prod_d;
		end
		case (ctrl.acc_op)
			ACC_LOAD: acc_q <= {prod_q[40], prod_q};
			ACC_ADD:  acc_q <= acc_q + {prod_q[40], prod_q};
			ACC_ADDC: acc_q <= acc_q + {{8{cfg.line_c[33]}}, cfg.line_c};
			default:  acc_q <= acc_q;
		endcase
	end

	// single-step operations
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_ERR: begin
				err_q <= $signed({3'd0, cfg.target_heading}) - $signed({{2{hd_q[15]}}, hd_q});
			end
			OP_HQ: begin
				hq_q <= prod_q[40] ? (22'd0 - hq_mag) : hq_mag;
			end
			OP_SIDE: begin
				side_neg_q <= acc_q[41];
				side_pos_q <= !acc_q[41] && (acc_q != '0);
			end
			OP_SUM: begin
				if (side_pos_q) begin
					s_q <= {{4{hq_q[21]}}, hq_q} + dg_term;
				end else if (side_neg_q) begin
					s_q <= {{4{hq_q[21]}}, hq_q} - dg_term;
				end else begin
					s_q <= {{4{hq_q[21]}}, hq_q};
				end
			end
			OP_DINIT: begin
				num_q <= s_mag + {17'd0, dvs[9:1]};
				neg_q <= s_q[25];
			end
			OP_DCHK: begin
				ovf_q <= (num_q[25:16] >= dvs);
				rem_q <= num_q[25:16];
				dq_q  <= num_q[15:0];
			end
			OP_DSTEP: begin
				if (!ovf_q) begin
					rem_q <= trial_ge ? 10'(trial - {1'b0, dvs}) : trial[9:0];
					dq_q  <= {dq_q[14:0], trial_ge};
				end
			end
			OP_CLAMP: begin
				if (neg_q) begin
					p_q <= ({1'b0, qv} > P_MID) ? 17'd0 : P_MID - {1'b0, qv};
				end else begin
					p_q <= ({1'b0, qv} >= P_MID) ? P_TOP : P_MID + {1'b0, qv};
				end
			end
			OP_IDX: begin
				idx_q  <= prod_q[16 +: AW];
				frac_q <= prod_q[15:0];
			end
			OP_CMD: begin
				cmd_q <= CMD_BASE + y_sum[22:12];
			end
			default: begin
			end
		endcase
	end

	// last command sent, cleared so the first sample always goes out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (emit) begin
			last_q <= cmd_q;
		end
	end

	assign same = (cmd_q == last_q);
	assign cmd  = cmd_q;

`ifndef SYNTHESIS
	a_emit_changed: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !same)
		else $error("unchanged command sent again");
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_DSTEP && !ovf_q) |-> (rem_q < dvs))
		else $error("divider remainder not below divisor");
`endif

endmodule

/* src/line_follow_steering.sv */
// ----------------------------------------------------------------------------
// line_follow_steering
// Steering command for following a straight path line, mapped through a
// sigmoid table; a command goes out only when it changes.
// ----------------------------------------------------------------------------
// Usage:
//   sample  - position requests (pos_x, pos_y, car_heading), valid/ready.
//   steer   - steering_command results (1000..2000), valid/ready.
//   cfg_*   - register writes, taken on any clock with cfg_wr_en high;
//             write only while no request is in flight.
// Each request runs through a 20-step microprogram on one shared multiplier
// and datapath. The quotient by sigmoid_scale takes 16 one-bit steps of the
// divider. A new request is accepted only once the program is back at its
// wait step, after the previous one has been sent or found unchanged.
// A result waits in the output register while the next request is taken;
// if the receiver still holds the previous result when a new one is ready,
// the program waits at its last step until that one is taken.
// Reset (arst_n low) returns the program to its wait step, drops any pending
// result, loads the register defaults and clears the last command to zero,
// so the first request always produces a command.
// ----------------------------------------------------------------------------
module line_follow_steering import lfs_pkg::*; #(
	parameter int unsigned SIGMOID_ENTRIES = SIG_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	lfs_in_if.sink            sample,
	lfs_out_if.source         steer,
	input  logic              cfg_wr_en,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata
);

	cfg_t             cfg_q;
	ctrl_t            ctrl;
	st_t              st;
	logic             in_ready;
	logic             in_fire;
	logic             out_busy;
	logic             emit;
	logic             same;
	logic [CMD_W-1:0] cmd;
	logic             out_valid_q;
	logic [CMD_W-1:0] out_cmd_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_a         <= '0;
			cfg_q.line_b         <= '0;
			cfg_q.line_c         <= '0;
			cfg_q.target_heading <= '0;
			cfg_q.heading_gain   <= HG_RST;
			cfg_q.distance_gain  <= DG_RST;
			cfg_q.sigmoid_scale  <= SCALE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_LINE_A:    cfg_q.line_a         <= cfg_wdata[16:0];
				REG_LINE_B:    cfg_q.line_b         <= cfg_wdata[16:0];
				REG_LINE_C:    cfg_q.line_c         <= cfg_wdata[33:0];
				REG_TARGET_HD: cfg_q.target_heading <= cfg_wdata[14:0];
				REG_HD_GAIN:   cfg_q.heading_gain   <= cfg_wdata[15:0];
				REG_DIST_GAIN: cfg_q.distance_gain  <= cfg_wdata[11:0];
				REG_SIG_SCALE: cfg_q.sigmoid_scale  <= cfg_wdata[9:0];
				default: begin
				end
			endcase
		end
	end

	// handshake status for the sequencer
	assign in_fire  = sample.valid && in_ready;
	assign out_busy = out_valid_q && !steer.ready;
	assign emit     = (ctrl.op == OP_EMIT) && !out_busy;
	assign st       = '{in_valid: sample.valid, out_busy: out_busy, same: same};

	lfs_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.st       (st),
		.ctrl     (ctrl),
		.in_ready (in_ready)
	);

	lfs_datapath #(
		.SIGMOID_ENTRIES(SIGMOID_ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.cfg         (cfg_q),
		.cap         (in_fire),
		.pos_x       (sample.pos_x),
		.pos_y       (sample.pos_y),
		.car_heading (sample.car_heading),
		.emit        (emit),
		.same        (same),
		.cmd         (cmd)
	);

	// output register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (steer.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_cmd_q <= cmd;
		end
	end

	assign sample.ready           = in_ready;
	assign steer.valid            = out_valid_q;
	assign steer.steering_command = out_cmd_q;

`ifndef SYNTHESIS
	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (out_valid_q && out_cmd_q >= CMD_BASE && out_cmd_q <= 11'd2000))
		else $error("emitted command missing or out of range");
`endif

endmodule

/* sim/tb_line_follow_steering.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_line_follow_steering
// Self-checking bench for the line follow steering block. Position requests
// go in through a bursty driver and steering commands are taken by a receiver
// under several back-pressure patterns. Each accepted request is scored
// against a bit-accurate fixed-point copy of the steering law: line side,
// heading error, gain sum, scaling, sigmoid table interpolation and the
// send-on-change rule. The register file is reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb_line_follow_steering import lfs_pkg::*; ();

	typedef longint unsigned u64_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] car_heading;
	} sample_t;

	typedef enum logic [1:0] {
		STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HEAVY
	} stall_mode_t;

	localparam logic [CIDX_W-1:0] REG_UNMAPPED = 3'd7;
	localparam int unsigned LUT_N        = SIG_ENTRIES_DEF;
	localparam int          DRAIN_CYCLES = 48;
	localparam int          HOLD_CYCLES  = 600;
	localparam int          QUIET_LIMIT  = 4000;
	localparam int          RAND_PHASES  = 10;
	localparam int          RAND_ITEMS   = 140;
	localparam int          REPORT_MAX   = 10;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [CIDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]    cfg_wdata;

	lfs_in_if  sample_if ();
	lfs_out_if steer_if ();

	line_follow_steering u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_if),
		.steer     (steer_if),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow registers and send-on-change state
	cfg_t             shadow_cfg;
	logic [CMD_W-1:0] last_steer = '0;
	u64_t             sig_lut [0:LUT_N];

	sample_t          sample_q [$];
	logic [CMD_W-1:0] steer_exp_q [$];

	int          err_count    = 0;
	int          quiet_cycles = 0;
	int          gap_max      = 0;
	int          burst_max    = 0;
	int          gap_left     = 0;
	int          burst_left   = 0;
	stall_mode_t stall_mode   = STALL_NONE;
	int          hold_req     = 0;
	int          hold_seen    = 0;
	int          hold_left    = 0;
	int unsigned pat_cnt      = 0;

	// ------------------------------------------------------------------
	// Fixed-point steering law
	// ------------------------------------------------------------------

	// e^(u/8) in Q.30 for u in Q3.12, truncated Taylor terms
	function automatic u64_t exp_eighth_q30(input u64_t u);
		u64_t term;
		u64_t acc;
		term = u64_t'(1) << 30;
		acc  = term;
		for (int k = 1; k <= 14; k++) begin
			term = (term * u) / (u64_t'(32768) * u64_t'(k));
			acc  = acc + term;
		end
		return acc;
	endfunction

	// 1000*sigmoid(t) in Q.12
	function automatic u64_t sigmoid_q12(input longint t);
		u64_t u;
		u64_t r;
		u64_t q;
		u64_t v;
		u = (t < 0) ? u64_t'(-t) : u64_t'(t);
		if (u > 32768) u = 32768;
		r = (u64_t'(1) << 60) / exp_eighth_q30(u);
		// raise 1/e^(u/8) to the eighth power
		for (int j = 0; j < 3; j++) r = (r * r) >> 30;
		q = (u64_t'(1) << 60) / ((u64_t'(1) << 30) + r);
		v = (u64_t'(1000) * q + (u64_t'(1) << 17)) >> 18;
		return (t < 0) ? (u64_t'(4096000) - v) : v;
	endfunction

	// Quotient rounded half away from zero
	function automatic longint div_half_away(input longint a, input u64_t d);
		u64_t m;
		u64_t q;
		m = (a < 0) ? u64_t'(-a) : u64_t'(a);
		q = (m + d / 2) / d;
		return (a < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [CMD_W-1:0] steer_from_sample(input sample_t smp,
			input cfg_t c);
		longint line_sum;
		longint side;
		longint err;
		longint hq;
		longint total;
		longint t;
		longint p;
		u64_t   scale;
		u64_t   pos;
		u64_t   idx;
		u64_t   frac;
		u64_t   yv;
		line_sum = longint'($signed(c.line_a)) * longint'(smp.pos_x)
			+ longint'($signed(c.line_b)) * longint'(smp.pos_y)
			+ longint'($signed(c.line_c));
		side = (line_sum > 0) ? 1 : ((line_sum < 0) ? -1 : 0);
		err = longint'(c.target_heading) - longint'(smp.car_heading);
		hq = div_half_away(longint'(c.heading_gain) * err, 4096);
		total = hq + side * longint'(c.distance_gain) * 4096;
		// zero scale counts as one
		scale = (c.sigmoid_scale == '0) ? 1 : u64_t'(c.sigmoid_scale);
		t = div_half_away(total, scale);
		// saturate at the table ends
		p = t + 32768;
		if (p < 0) p = 0;
		if (p > 65536) p = 65536;
		pos  = u64_t'(p) * LUT_N;
		idx  = pos >> 16;
		frac = pos & 65535;
		if (idx >= LUT_N) yv = sig_lut[LUT_N];
		else yv = (sig_lut[idx] * (65536 - frac) + sig_lut[idx + 1] * frac) >> 16;
		return CMD_W'(u64_t'(CMD_BASE) + ((yv + 2048) >> 12));
	endfunction

	task automatic note_fail(input string msg);
		err_count++;
		if (err_count <= REPORT_MAX) $display("%s", msg);
	endtask

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Request driver: bursts with random gaps
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		sample_t nxt;
		if (!arst_n) begin
			sample_if.valid       <= 1'b0;
			sample_if.pos_x       <= '0;
			sample_if.pos_y       <= '0;
			sample_if.car_heading <= '0;
		end else if (!sample_if.valid || sample_if.ready) begin
			if (gap_left > 0) begin
				gap_left--;
				sample_if.valid <= 1'b0;
			end else if (sample_q.size() > 0) begin
				nxt = sample_q.pop_front();
				sample_if.pos_x       <= nxt.pos_x;
				sample_if.pos_y       <= nxt.pos_y;
				sample_if.car_heading <= nxt.car_heading;
				sample_if.valid       <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, burst_max);
					gap_left   = $urandom_range(0, gap_max);
				end
			end else begin
				sample_if.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Command receiver: stall pattern plus an occasional long hold-off
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		logic rdy;
		if (!arst_n) begin
			steer_if.ready <= 1'b0;
		end else begin
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			pat_cnt++;
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				case (stall_mode)
					STALL_RANDOM:  rdy = ($urandom_range(0, 3) != 0);
					STALL_PATTERN: rdy = ((pat_cnt % 7) >= 3);
					STALL_HEAVY:   rdy = ($urandom_range(0, 4) == 0);
					default:       rdy = 1'b1;
				endcase
			end
			steer_if.ready <= rdy;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predict on each accepted request, check each command
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		sample_t          smp;
		logic [CMD_W-1:0] cmd;
		logic [CMD_W-1:0] want;
		logic             busy;
		busy = cfg_wr_en;
		if (arst_n) begin
			if (sample_if.valid && sample_if.ready) begin
				busy = 1'b1;
				smp.pos_x       = sample_if.pos_x;
				smp.pos_y       = sample_if.pos_y;
				smp.car_heading = sample_if.car_heading;
				cmd = steer_from_sample(smp, shadow_cfg);
				// emit only on change
				if (cmd != last_steer) begin
					last_steer = cmd;
					steer_exp_q.push_back(cmd);
				end
			end
			if (steer_if.valid && steer_if.ready) begin
				busy = 1'b1;
				if (steer_exp_q.size() == 0) begin
					note_fail($sformatf("unexpected steering_command %0d at %0t",
						steer_if.steering_command, $realtime));
				end else begin
					want = steer_exp_q.pop_front();
					if (want !== steer_if.steering_command)
						note_fail($sformatf("steering_command mismatch: expected %0d, got %0d at %0t",
							want, steer_if.steering_command, $realtime));
				end
			end
		end
		quiet_cycles = busy ? 0 : quiet_cycles + 1;
	end

	// Watchdog on handshake activity
	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [CIDX_W-1:0] idx, input longint value);
		logic [CFG_W-1:0] data;
		data = CFG_W'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_LINE_A:    shadow_cfg.line_a         = data[16:0];
			REG_LINE_B:    shadow_cfg.line_b         = data[16:0];
			REG_LINE_C:    shadow_cfg.line_c         = data[33:0];
			REG_TARGET_HD: shadow_cfg.target_heading = data[14:0];
			REG_HD_GAIN:   shadow_cfg.heading_gain   = data[15:0];
			REG_DIST_GAIN: shadow_cfg.distance_gain  = data[11:0];
			REG_SIG_SCALE: shadow_cfg.sigmoid_scale  = data[9:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input longint a, input longint b, input longint c,
			input longint th, input longint hg, input longint dg, input longint sc);
		write_reg(REG_LINE_A, a);
		write_reg(REG_LINE_B, b);
		write_reg(REG_LINE_C, c);
		write_reg(REG_TARGET_HD, th);
		write_reg(REG_HD_GAIN, hg);
		write_reg(REG_DIST_GAIN, dg);
		write_reg(REG_SIG_SCALE, sc);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic push_sample(input longint x, input longint y, input longint h);
		sample_t s;
		s.pos_x       = POS_W'(x);
		s.pos_y       = POS_W'(y);
		s.car_heading = POS_W'(h);
		sample_q.push_back(s);
	endtask

	// Wait until every request is taken and every command has arrived
	task automatic drain();
		@(posedge clk);
		#1;
		while (sample_q.size() > 0 || sample_if.valid || steer_exp_q.size() > 0) begin
			@(posedge clk);
			#1;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic longint pick_range(input longint lo, input longint hi);
		case ($urandom_range(0, 4))
			0:       return lo;
			1:       return hi;
			default: return lo + longint'($urandom_range(0, int'(hi - lo)));
		endcase
	endfunction

	task automatic random_config();
		longint c;
		longint hg;
		longint sc;
		case ($urandom_range(0, 7))
			0:       c = -64'sd8589934592;
			1:       c = 64'sd8589934591;
			2:       c = 0;
			default: c = longint'($urandom_range(0, 33554431)) - 16777216;
		endcase
		case ($urandom_range(0, 5))
			0:       hg = 0;
			1:       hg = 65535;
			2:       hg = $urandom_range(0, 65535);
			default: hg = $urandom_range(0, 8191);
		endcase
		case ($urandom_range(0, 9))
			0:       sc = 0;
			1:       sc = 1;
			2:       sc = 1023;
			default: sc = $urandom_range(1, 1023);
		endcase
		write_all(pick_range(-65535, 65535), pick_range(-65535, 65535), c,
			($urandom_range(0, 7) == 0) ? 32767 : pick_range(0, 25736),
			hg, pick_range(0, 4095), sc);
	endtask

	task automatic random_samples(input int n);
		sample_t prev;
		longint  h;
		prev = '0;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 19))
				0, 1: begin
					// repeat the last sample, usually no new command
					sample_q.push_back(prev);
				end
				2: begin
					h = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
					push_sample(-32768 + $urandom_range(0, 1) * 65535,
						-32768 + $urandom_range(0, 1) * 65535, h);
				end
				3, 4, 5: begin
					// heading close to the target
					h = longint'(shadow_cfg.target_heading)
						+ longint'($urandom_range(0, 400)) - 200;
					push_sample($urandom, $urandom, h);
				end
				default: push_sample($urandom, $urandom, $urandom);
			endcase
			prev = sample_q[$];
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		longint t_i;
		cfg_wr_en             = 1'b0;
		cfg_index             = '0;
		cfg_wdata             = '0;
		arst_n                = 1'b0;

		shadow_cfg = '0;
		shadow_cfg.heading_gain  = HG_RST;
		shadow_cfg.distance_gain = DG_RST;
		shadow_cfg.sigmoid_scale = SCALE_RST;
		for (int i = 0; i <= LUT_N; i++) begin
			t_i = -32768 + longint'((u64_t'(65536) * u64_t'(i)) / LUT_N);
			sig_lut[i] = sigmoid_q12(t_i);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Default registers: degenerate zero line, field extremes, a repeat
		push_sample(0, 0, 0);
		push_sample(0, 0, 0);
		push_sample(32767, 32767, 32767);
		push_sample(-32768, -32768, -32768);
		push_sample(0, 0, -32768);
		push_sample(0, 0, 32767);
		drain();

		// Diagonal line: on the line and either side of it
		write_all(1, -1, 0, 0, HG_RST, DG_RST, SCALE_RST);
		push_sample(5, 5, 0);
		push_sample(6, 5, 0);
		push_sample(5, 6, 0);
		push_sample(-32768, 32767, 0);
		push_sample(32767, -32768, 0);
		drain();

		// Unmapped index ignored; negative constant line, heading past two pi,
		// maximum gains and a zero scale push the sum off the table
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_UNMAPPED;
		cfg_wdata <= '1;
		write_all(0, 0, -1, 32767, 65535, 4095, 0);
		push_sample(0, 0, 32767);
		push_sample(0, 0, -32768);
		push_sample(1, 1, 0);
		drain();

		// Zero gains hold the command mid-scale; extreme line terms
		write_all(-65535, 65535, -64'sd8589934592, 25736, 0, 0, 1023);
		push_sample(-32768, 32767, 100);
		push_sample(32767, -32768, -100);
		drain();
		write_reg(REG_LINE_C, 64'sd8589934591);
		write_reg(REG_DIST_GAIN, 4095);
		write_reg(REG_SIG_SCALE, 1);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		push_sample(32767, 32767, 0);
		push_sample(-32768, -32768, 0);
		drain();

		// Random phases
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			random_config();
			if (ph == 0) begin
				stall_mode = STALL_NONE;
				gap_max    = 0;
				burst_max  = 0;
			end else if (ph == 2) begin
				// sender keeps offering while the receiver holds off
				stall_mode = STALL_NONE;
				gap_max    = 0;
				burst_max  = 0;
				hold_req++;
			end else begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				case ($urandom_range(0, 3))
					0:       gap_max = 0;
					1:       gap_max = 3;
					2:       gap_max = 12;
					default: gap_max = 30;
				endcase
				burst_max = ($urandom_range(0, 1) != 0) ? 4 : 16;
			end
			random_samples(RAND_ITEMS);
			drain();
		end

		if (steer_exp_q.size() != 0)
			note_fail($sformatf("%0d steering commands never arrived",
				steer_exp_q.size()));
		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
